>>> src/count_sketch_heavy_hitter_top_macros.svh
// Assertion macros shared by the sketch RTL
`ifndef COUNT_SKETCH_HEAVY_HITTER_TOP_MACROS_SVH
`define COUNT_SKETCH_HEAVY_HITTER_TOP_MACROS_SVH
`ifndef ASSERT_OFF
`define CSHH_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("sketch check failed");
`define CSHH_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("sketch check failed");
`else
`define CSHH_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define CSHH_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

>>> src/cshh_pkg.sv
`default_nettype none
package cshh_pkg;
    localparam int ROWS        = 27;
    localparam int MAX_BUCKETS = 512;
    localparam int NCNT        = ROWS * MAX_BUCKETS;
    localparam int ADDR_W      = $clog2(NCNT);
    localparam int ROW_W       = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int SEED_IDX_W  = ROW_W + 1;
    localparam int DW          = 32;
    localparam int CMD_W       = 3;
    localparam int IDX_W       = 14;
    localparam int BKT_W       = 10;
    localparam int CFG_IDX_W   = 1;
    localparam int HASH_LAT    = 4;
    localparam int MOD_BITS    = 4;
    localparam int MOD_STEPS   = DW / MOD_BITS;
    localparam int CNT_W       = $clog2(MOD_STEPS);

    localparam logic [CFG_IDX_W-1:0] CFG_BUCKETS   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 1'd1;

    localparam logic [CMD_W-1:0] CMD_ADD  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_SUB  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_QRY  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_LOAD = 3'd3;
    localparam logic [CMD_W-1:0] CMD_READ = 3'd4;

    localparam logic [DW-1:0] HC1 = 32'hed5ad4bb;
    localparam logic [DW-1:0] HC2 = 32'hac4c1b51;
    localparam logic [DW-1:0] HC3 = 32'h31848bab;

    localparam logic [DW-1:0] SEEDS [2*ROWS] = '{
        32'd3499211612, 32'd581869302,  32'd3890346734, 32'd3586334585,
        32'd545404204,  32'd4161255391, 32'd3922919429, 32'd949333985,
        32'd2715962298, 32'd1323567403, 32'd418932835,  32'd2350294565,
        32'd1196140740, 32'd809094426,  32'd2348838239, 32'd4264392720,
        32'd4112460519, 32'd4279768804, 32'd4144164697, 32'd4156218106,
        32'd676943009,  32'd3117454609, 32'd4168664243, 32'd4213834039,
        32'd4111000746, 32'd471852626,  32'd2084672536, 32'd3427838553,
        32'd3437178460, 32'd1275731771, 32'd609397212,  32'd20544909,
        32'd1811450929, 32'd483031418,  32'd3933054126, 32'd2747762695,
        32'd3402504553, 32'd3772830893, 32'd4120988587, 32'd2163214728,
        32'd2816384844, 32'd3427077306, 32'd153380495,  32'd1551745920,
        32'd3646982597, 32'd910208076,  32'd4011470445, 32'd2926416934,
        32'd2915145307, 32'd1712568902, 32'd3254469058, 32'd3181055693,
        32'd3191729660, 32'd2039073006
    };

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_DISP, S_HASH, S_CAPT, S_MOD, S_RD, S_USE, S_FIN
    } t_state;

    typedef struct packed {
        logic cap;
        logic row_clr;
        logic row_inc;
        logic capt;
        logic mod_step;
        logic mem_rd;
        logic cnt_upd;
        logic srt_clr;
        logic srt_ins;
        logic idx_wr;
        logic idx_rd;
        logic clr_wr;
        logic out_ld;
    } t_ctl;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             row_last;
        logic             clr_last;
        logic             out_free;
    } t_sts;
endpackage
`default_nettype wire

>>> src/cshh_hash.sv
`default_nettype none
module cshh_hash (
    input  wire logic                    i_clk,
    input  wire logic [cshh_pkg::DW-1:0] i_seed,
    input  wire logic [cshh_pkg::DW-1:0] i_key,
    output logic      [cshh_pkg::DW-1:0] o_hash
);
    logic [cshh_pkg::DW-1:0] r_a, r_b, r_c, r_h;
    logic [cshh_pkg::DW-1:0] v0, v1, vb, vc;

    always_comb begin
        v0 = i_key + 32'd1;
        v1 = v0 ^ (v0 >> 17);
        vb = r_a ^ i_seed;
        vb = vb ^ (vb >> 11);
        vc = r_b ^ (r_b >> 15);
    end

    always_ff @(posedge i_clk) begin
        r_a <= v1 * cshh_pkg::HC1;
        r_b <= vb * cshh_pkg::HC2;
        r_c <= vc * cshh_pkg::HC3;
        r_h <= i_seed ^ (r_c ^ (r_c >> 14));
    end

    assign o_hash = r_h;
endmodule
`default_nettype wire

>>> src/cshh_ctrl.sv
`default_nettype none
`include "count_sketch_heavy_hitter_top_macros.svh"
module cshh_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_stall,
    input  wire cshh_pkg::t_sts i_sts,
    output cshh_pkg::t_ctl      o_ctl
);
    cshh_pkg::t_state              r_st, n_st;
    logic [cshh_pkg::CNT_W-1:0]    r_cnt, n_cnt;
    logic                          ins;

    assign ins = (i_sts.cmd == cshh_pkg::CMD_ADD) || (i_sts.cmd == cshh_pkg::CMD_SUB)
              || (i_sts.cmd == cshh_pkg::CMD_QRY);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st  <= cshh_pkg::S_CLEAR;
            r_cnt <= '0;
        end else begin
            r_st  <= n_st;
            r_cnt <= n_cnt;
        end
    end

    always_comb begin
        n_st  = r_st;
        n_cnt = r_cnt;
        case (r_st)
            cshh_pkg::S_CLEAR: begin
                if (i_sts.clr_last) n_st = cshh_pkg::S_IDLE;
            end
            cshh_pkg::S_IDLE: begin
                if (i_in_valid) n_st = cshh_pkg::S_DISP;
            end
            cshh_pkg::S_DISP: begin
                n_cnt = '0;
                if (ins) n_st = cshh_pkg::S_HASH;
                else if (i_sts.cmd == cshh_pkg::CMD_READ) n_st = cshh_pkg::S_FIN;
                else n_st = cshh_pkg::S_IDLE;
            end
            cshh_pkg::S_HASH: begin
                if (r_cnt == cshh_pkg::CNT_W'(cshh_pkg::HASH_LAT - 1)) begin
                    n_st  = cshh_pkg::S_CAPT;
                    n_cnt = '0;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            cshh_pkg::S_CAPT: n_st = cshh_pkg::S_MOD;
            cshh_pkg::S_MOD: begin
                if (r_cnt == cshh_pkg::CNT_W'(cshh_pkg::MOD_STEPS - 1)) begin
                    n_st  = cshh_pkg::S_RD;
                    n_cnt = '0;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            cshh_pkg::S_RD: n_st = cshh_pkg::S_USE;
            cshh_pkg::S_USE: begin
                if (!i_sts.row_last) n_st = cshh_pkg::S_HASH;
                else if (i_sts.cmd == cshh_pkg::CMD_QRY) n_st = cshh_pkg::S_FIN;
                else n_st = cshh_pkg::S_IDLE;
            end
            cshh_pkg::S_FIN: begin
                if (i_sts.out_free) n_st = cshh_pkg::S_IDLE;
            end
            default: n_st = cshh_pkg::S_CLEAR;
        endcase
    end

    always_comb begin
        o_ctl      = '0;
        o_in_stall = 1'b1;
        case (r_st)
            cshh_pkg::S_CLEAR: o_ctl.clr_wr = 1'b1;
            cshh_pkg::S_IDLE: begin
                o_in_stall = 1'b0;
                o_ctl.cap  = i_in_valid;
            end
            cshh_pkg::S_DISP: begin
                o_ctl.row_clr = ins;
                o_ctl.srt_clr = ins;
                o_ctl.idx_wr  = (i_sts.cmd == cshh_pkg::CMD_LOAD);
                o_ctl.idx_rd  = (i_sts.cmd == cshh_pkg::CMD_READ);
            end
            cshh_pkg::S_CAPT: o_ctl.capt = 1'b1;
            cshh_pkg::S_MOD:  o_ctl.mod_step = 1'b1;
            cshh_pkg::S_RD:   o_ctl.mem_rd = 1'b1;
            cshh_pkg::S_USE: begin
                o_ctl.cnt_upd = (i_sts.cmd != cshh_pkg::CMD_QRY);
                o_ctl.srt_ins = (i_sts.cmd == cshh_pkg::CMD_QRY);
                o_ctl.row_inc = !i_sts.row_last;
            end
            cshh_pkg::S_FIN: o_ctl.out_ld = i_sts.out_free;
            default: o_ctl = '0;
        endcase
    end

    `CSHH_ASSERT_IMP(a_out_free, i_clk, i_rst_n, o_ctl.out_ld, i_sts.out_free)
    `CSHH_ASSERT_NXT(a_clr_done, i_clk, i_rst_n, r_st == cshh_pkg::S_CLEAR && i_sts.clr_last, r_st == cshh_pkg::S_IDLE)
endmodule
`default_nettype wire

>>> src/cshh_dpath.sv
`default_nettype none
`include "count_sketch_heavy_hitter_top_macros.svh"
module cshh_dpath (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire cshh_pkg::t_ctl                 i_ctl,
    output cshh_pkg::t_sts                      o_sts,
    input  wire logic                           i_cfg_we,
    input  wire logic [cshh_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [cshh_pkg::DW-1:0]        i_cfg_data,
    input  wire logic [cshh_pkg::CMD_W-1:0]     i_command,
    input  wire logic [cshh_pkg::DW-1:0]        i_key,
    input  wire logic [cshh_pkg::DW-1:0]        i_amount,
    input  wire logic [cshh_pkg::IDX_W-1:0]     i_counter_index,
    input  wire logic signed [cshh_pkg::DW-1:0] i_counter_value,
    input  wire logic                           i_out_stall,
    output logic                                o_out_valid,
    output logic signed [cshh_pkg::DW-1:0]      o_estimate,
    output logic                                o_is_heavy,
    output logic signed [cshh_pkg::DW-1:0]      o_read_value
);
    localparam int MID = cshh_pkg::ROWS / 2;
    localparam int LO  = (cshh_pkg::ROWS % 2 == 0) ? MID - 1 : MID;
    localparam int RW  = cshh_pkg::BKT_W;

    logic [cshh_pkg::DW-1:0]        r_mem [cshh_pkg::NCNT];
    logic [cshh_pkg::DW-1:0]        r_rdata;
    logic [cshh_pkg::ADDR_W-1:0]    r_clr_addr;
    logic [RW-1:0]                  r_bc;
    logic signed [cshh_pkg::DW-1:0] r_thr;
    logic [cshh_pkg::CMD_W-1:0]     r_cmd;
    logic [cshh_pkg::DW-1:0]        r_key, r_amt;
    logic [cshh_pkg::IDX_W-1:0]     r_idx;
    logic [cshh_pkg::DW-1:0]        r_val;
    logic [cshh_pkg::ROW_W-1:0]     r_row;
    logic [cshh_pkg::DW-1:0]        r_q;
    logic [RW-1:0]                  r_rem, n_rem;
    logic                           r_neg;
    logic [cshh_pkg::ROWS-1:0]      r_sv, n_sv;
    logic signed [cshh_pkg::DW-1:0] r_sk [cshh_pkg::ROWS];
    logic signed [cshh_pkg::DW-1:0] n_sk [cshh_pkg::ROWS];
    logic                           r_ovalid;
    logic signed [cshh_pkg::DW-1:0] r_est, r_rv;
    logic                           r_heavy;

    logic [cshh_pkg::DW-1:0]         h_bkt, h_sgn;
    logic [cshh_pkg::SEED_IDX_W-1:0] sidx_b, sidx_s;
    logic [RW-1:0]                   b_eff;
    logic [RW:0]                     t2;
    logic [cshh_pkg::ADDR_W-1:0]     slot, addr;
    logic                            idx_ok, we, sub;
    logic [cshh_pkg::DW-1:0]         wdata;
    logic signed [cshh_pkg::DW-1:0]  ins_v, med;
    logic signed [cshh_pkg::DW:0]    msum;
    logic [cshh_pkg::ROWS-1:0]       gt;

    assign sidx_b = {r_row, 1'b0};
    assign sidx_s = {r_row, 1'b1};

    cshh_hash u_hash_bkt (
        .i_clk(i_clk), .i_seed(cshh_pkg::SEEDS[sidx_b]), .i_key(r_key), .o_hash(h_bkt)
    );
    cshh_hash u_hash_sgn (
        .i_clk(i_clk), .i_seed(cshh_pkg::SEEDS[sidx_s]), .i_key(r_key), .o_hash(h_sgn)
    );

    always_comb begin
        if (r_bc == '0) b_eff = RW'(1);
        else if (32'(r_bc) > cshh_pkg::MAX_BUCKETS) b_eff = RW'(cshh_pkg::MAX_BUCKETS);
        else b_eff = r_bc;
    end

    // radix-16 restoring remainder, MSB first
    always_comb begin
        n_rem = r_rem;
        t2    = '0;
        for (int k = 0; k < cshh_pkg::MOD_BITS; k++) begin
            t2 = {n_rem, r_q[cshh_pkg::DW-1-k]};
            if (t2 >= {1'b0, b_eff}) t2 = t2 - {1'b0, b_eff};
            n_rem = t2[RW-1:0];
        end
    end

    assign slot   = cshh_pkg::ADDR_W'(32'(r_row) * cshh_pkg::MAX_BUCKETS)
                  + cshh_pkg::ADDR_W'(r_rem);
    assign idx_ok = 32'(r_idx) < cshh_pkg::NCNT;
    assign sub    = r_neg ^ (r_cmd == cshh_pkg::CMD_SUB);

    always_comb begin
        if (i_ctl.clr_wr) addr = r_clr_addr;
        else if (i_ctl.idx_wr || i_ctl.idx_rd) addr = cshh_pkg::ADDR_W'(r_idx);
        else addr = slot;
        we = i_ctl.clr_wr || (i_ctl.idx_wr && idx_ok) || i_ctl.cnt_upd;
        if (i_ctl.clr_wr) wdata = '0;
        else if (i_ctl.idx_wr) wdata = r_val;
        else if (sub) wdata = r_rdata - r_amt;
        else wdata = r_rdata + r_amt;
    end

    always_ff @(posedge i_clk) begin
        if (we) r_mem[addr] <= wdata;
        if (i_ctl.mem_rd || i_ctl.idx_rd) r_rdata <= r_mem[addr];
    end

    // insertion into a sorted row of cells; empty cells read as +inf
    assign ins_v = r_neg ? -$signed(r_rdata) : $signed(r_rdata);
    always_comb begin
        for (int i = 0; i < cshh_pkg::ROWS; i++) begin
            gt[i] = !r_sv[i] || (r_sk[i] > ins_v);
        end
        for (int i = 0; i < cshh_pkg::ROWS; i++) begin
            n_sk[i] = r_sk[i];
            n_sv[i] = r_sv[i];
            if (gt[i]) begin
                if (i > 0 && gt[(i > 0) ? i - 1 : 0]) begin
                    n_sk[i] = r_sk[(i > 0) ? i - 1 : 0];
                    n_sv[i] = r_sv[(i > 0) ? i - 1 : 0];
                end else begin
                    n_sk[i] = ins_v;
                    n_sv[i] = 1'b1;
                end
            end
        end
    end

    always_comb begin
        msum = (cshh_pkg::DW+1)'(r_sk[LO]) + (cshh_pkg::DW+1)'(r_sk[MID]);
        if (cshh_pkg::ROWS % 2 == 0) begin
            if (msum[cshh_pkg::DW] && msum[0]) msum = msum + 1'b1;
            med = cshh_pkg::DW'(msum >>> 1);
        end else begin
            med = r_sk[MID];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
            r_bc       <= RW'(11);
            r_thr      <= '0;
            r_ovalid   <= 1'b0;
            r_sv       <= '0;
        end else begin
            if (i_ctl.clr_wr) r_clr_addr <= r_clr_addr + 1'b1;
            if (i_cfg_we && i_cfg_idx == cshh_pkg::CFG_BUCKETS) r_bc <= i_cfg_data[RW-1:0];
            if (i_cfg_we && i_cfg_idx == cshh_pkg::CFG_THRESHOLD) r_thr <= $signed(i_cfg_data);
            if (i_ctl.out_ld) r_ovalid <= 1'b1;
            else if (!i_out_stall) r_ovalid <= 1'b0;
            if (i_ctl.srt_clr) r_sv <= '0;
            else if (i_ctl.srt_ins) r_sv <= n_sv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.cap) begin
            r_cmd <= i_command;
            r_key <= i_key;
            r_amt <= i_amount;
            r_idx <= i_counter_index;
            r_val <= i_counter_value;
        end
        if (i_ctl.row_clr) r_row <= '0;
        else if (i_ctl.row_inc) r_row <= r_row + 1'b1;
        if (i_ctl.capt) begin
            r_q   <= h_bkt;
            r_rem <= '0;
            r_neg <= ~(^h_sgn);
        end else if (i_ctl.mod_step) begin
            r_q   <= r_q << cshh_pkg::MOD_BITS;
            r_rem <= n_rem;
        end
        if (i_ctl.srt_ins) r_sk <= n_sk;
        if (i_ctl.out_ld) begin
            if (r_cmd == cshh_pkg::CMD_QRY) begin
                r_est   <= med;
                r_heavy <= (med >= r_thr);
                r_rv    <= '0;
            end else begin
                r_est   <= '0;
                r_heavy <= 1'b0;
                r_rv    <= idx_ok ? $signed(r_rdata) : '0;
            end
        end
    end

    assign o_sts.cmd      = r_cmd;
    assign o_sts.row_last = (r_row == cshh_pkg::ROW_W'(cshh_pkg::ROWS - 1));
    assign o_sts.clr_last = (r_clr_addr == cshh_pkg::ADDR_W'(cshh_pkg::NCNT - 1));
    assign o_sts.out_free = !r_ovalid || !i_out_stall;

    assign o_out_valid  = r_ovalid;
    assign o_estimate   = r_est;
    assign o_is_heavy   = r_heavy;
    assign o_read_value = r_rv;

    `CSHH_ASSERT_IMP(a_med_full, i_clk, i_rst_n, i_ctl.out_ld && r_cmd == cshh_pkg::CMD_QRY, &r_sv)
    `CSHH_ASSERT_IMP(a_rem_range, i_clk, i_rst_n, i_ctl.mem_rd, r_rem < b_eff)
endmodule
`default_nettype wire

>>> src/count_sketch_heavy_hitter_top.sv
// One item at a time; per row the bucket and sign hash pipelines, the radix-16 remainder
// and the single counter memory port (read then write) are used in turn.
// A result waits in the output register while the next word is taken.
// Reset (synchronous, active low) clears all ROWS*MAX_BUCKETS counters, one per cycle;
// input is stalled while this runs, and configuration writes are taken throughout.
`default_nettype none
module count_sketch_heavy_hitter_top (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [cshh_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [cshh_pkg::DW-1:0]        i_cfg_data,
    input  wire logic                           i_in_valid,
    output logic                                o_in_stall,
    input  wire logic [cshh_pkg::CMD_W-1:0]     i_command,
    input  wire logic [cshh_pkg::DW-1:0]        i_key,
    input  wire logic [cshh_pkg::DW-1:0]        i_amount,
    input  wire logic [cshh_pkg::IDX_W-1:0]     i_counter_index,
    input  wire logic signed [cshh_pkg::DW-1:0] i_counter_value,
    output logic                                o_out_valid,
    input  wire logic                           i_out_stall,
    output logic signed [cshh_pkg::DW-1:0]      o_estimate,
    output logic                                o_is_heavy,
    output logic signed [cshh_pkg::DW-1:0]      o_read_value
);
    cshh_pkg::t_ctl ctl;
    cshh_pkg::t_sts sts;

    cshh_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_ctl      (ctl)
    );

    cshh_dpath u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_ctl           (ctl),
        .o_sts           (sts),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_command       (i_command),
        .i_key           (i_key),
        .i_amount        (i_amount),
        .i_counter_index (i_counter_index),
        .i_counter_value (i_counter_value),
        .i_out_stall     (i_out_stall),
        .o_out_valid     (o_out_valid),
        .o_estimate      (o_estimate),
        .o_is_heavy      (o_is_heavy),
        .o_read_value    (o_read_value)
    );
endmodule
`default_nettype wire

>>> tb/sv/tb_count_sketch_heavy_hitter_checker.sv
`default_nettype none
module tb_count_sketch_heavy_hitter_checker (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [cshh_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [cshh_pkg::DW-1:0]        i_cfg_data,
    input  wire logic                           i_in_valid,
    input  wire logic                           i_in_stall,
    input  wire logic [cshh_pkg::CMD_W-1:0]     i_command,
    input  wire logic [cshh_pkg::DW-1:0]        i_key,
    input  wire logic [cshh_pkg::DW-1:0]        i_amount,
    input  wire logic [cshh_pkg::IDX_W-1:0]     i_counter_index,
    input  wire logic signed [cshh_pkg::DW-1:0] i_counter_value,
    input  wire logic                           i_out_valid,
    input  wire logic                           i_out_stall,
    input  wire logic signed [cshh_pkg::DW-1:0] i_estimate,
    input  wire logic                           i_is_heavy,
    input  wire logic signed [cshh_pkg::DW-1:0] i_read_value,
    output int                                  o_fail_count,
    output int                                  o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic signed [cshh_pkg::DW-1:0] estimate;
        logic                           is_heavy;
        logic signed [cshh_pkg::DW-1:0] read_value;
    } t_answer;

    logic [cshh_pkg::DW-1:0]        sketch [cshh_pkg::NCNT];
    logic [cshh_pkg::BKT_W-1:0]     buckets;
    logic signed [cshh_pkg::DW-1:0] heavy_limit;
    t_answer                        answers_due [$];

    assign o_pending = answers_due.size();

    function automatic logic [cshh_pkg::DW-1:0] mix_key(logic [cshh_pkg::DW-1:0] seed,
                                                        logic [cshh_pkg::DW-1:0] key);
        logic [cshh_pkg::DW-1:0] v;
        v = key + 32'd1;
        v ^= v >> 17;
        v = v * cshh_pkg::HC1;
        v ^= seed;
        v ^= v >> 11;
        v = v * cshh_pkg::HC2;
        v ^= v >> 15;
        v = v * cshh_pkg::HC3;
        v ^= v >> 14;
        return seed ^ v;
    endfunction

    function automatic int bucket_of(int r, logic [cshh_pkg::DW-1:0] key);
        int unsigned b;
        b = buckets;
        if (b == 0) b = 1;
        if (b > cshh_pkg::MAX_BUCKETS) b = cshh_pkg::MAX_BUCKETS;
        return r * cshh_pkg::MAX_BUCKETS + int'(mix_key(cshh_pkg::SEEDS[2*r], key) % b);
    endfunction

    // even parity means negative sign
    function automatic logic row_negative(int r, logic [cshh_pkg::DW-1:0] key);
        return ~(^mix_key(cshh_pkg::SEEDS[2*r+1], key));
    endfunction

    function automatic t_answer median_of(logic [cshh_pkg::DW-1:0] key);
        longint vals [cshh_pkg::ROWS];
        longint x, est;
        logic [cshh_pkg::DW-1:0] c;
        int j;
        t_answer a;
        for (int r = 0; r < cshh_pkg::ROWS; r++) begin
            c = sketch[bucket_of(r, key)];
            if (row_negative(r, key)) c = -c;
            vals[r] = longint'(signed'(c));
        end
        for (int i = 1; i < cshh_pkg::ROWS; i++) begin
            x = vals[i];
            j = i;
            while (j > 0 && vals[j-1] > x) begin
                vals[j] = vals[j-1];
                j--;
            end
            vals[j] = x;
        end
        if (cshh_pkg::ROWS % 2 == 0)
            est = (vals[cshh_pkg::ROWS/2-1] + vals[cshh_pkg::ROWS/2]) / 2;
        else est = vals[cshh_pkg::ROWS/2];
        a.estimate = est[cshh_pkg::DW-1:0];
        a.is_heavy = est >= longint'(heavy_limit);
        a.read_value = '0;
        return a;
    endfunction

    task automatic add_answer(t_answer a);
        answers_due.insert(answers_due.size(), a);
    endtask

    task automatic report(string what, logic [cshh_pkg::DW-1:0] got,
                          logic [cshh_pkg::DW-1:0] want);
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
        o_fail_count++;
    endtask

    always @(posedge i_clk) begin
        t_answer a;
        logic neg;
        int s;
        if (!i_rst_n) begin
            foreach (sketch[i]) sketch[i] = '0;
            buckets = 10'd11;
            heavy_limit = '0;
            answers_due.delete();
            o_fail_count = 0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == cshh_pkg::CFG_BUCKETS)
                    buckets = i_cfg_data[cshh_pkg::BKT_W-1:0];
                else if (i_cfg_idx == cshh_pkg::CFG_THRESHOLD) heavy_limit = i_cfg_data;
            end
            if (i_out_valid && !i_out_stall) begin
                if (answers_due.size() == 0) begin
                    report("unexpected word", i_read_value, '0);
                end else begin
                    a = answers_due.pop_front();
                    if (i_estimate !== a.estimate) report("estimate", i_estimate, a.estimate);
                    if (i_is_heavy !== a.is_heavy) report("is_heavy", i_is_heavy, a.is_heavy);
                    if (i_read_value !== a.read_value)
                        report("read_value", i_read_value, a.read_value);
                end
            end
            if (i_in_valid && !i_in_stall) begin
                case (i_command)
                    cshh_pkg::CMD_ADD, cshh_pkg::CMD_SUB: begin
                        for (int r = 0; r < cshh_pkg::ROWS; r++) begin
                            s = bucket_of(r, i_key);
                            neg = row_negative(r, i_key) ^ (i_command == cshh_pkg::CMD_SUB);
                            sketch[s] = neg ? sketch[s] - i_amount : sketch[s] + i_amount;
                        end
                    end
                    cshh_pkg::CMD_QRY: add_answer(median_of(i_key));
                    cshh_pkg::CMD_LOAD:
                        if (i_counter_index < cshh_pkg::NCNT)
                            sketch[i_counter_index] = i_counter_value;
                    cshh_pkg::CMD_READ: begin
                        a = '0;
                        if (i_counter_index < cshh_pkg::NCNT)
                            a.read_value = sketch[i_counter_index];
                        add_answer(a);
                    end
                    default: ;
                endcase
            end
        end
    end
endmodule
`default_nettype wire

>>> tb/sv/tb_count_sketch_heavy_hitter_top.sv
`default_nettype none
module tb_count_sketch_heavy_hitter_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG = 40000;

    logic                              i_clk, i_rst_n;
    logic                              i_cfg_we;
    logic [cshh_pkg::CFG_IDX_W-1:0]    i_cfg_idx;
    logic [cshh_pkg::DW-1:0]           i_cfg_data;
    logic                              i_in_valid, o_in_stall;
    logic [cshh_pkg::CMD_W-1:0]        i_command;
    logic [cshh_pkg::DW-1:0]           i_key, i_amount;
    logic [cshh_pkg::IDX_W-1:0]        i_counter_index;
    logic signed [cshh_pkg::DW-1:0]    i_counter_value;
    logic                              o_out_valid;
    logic                              i_out_stall = 1'b0;
    logic signed [cshh_pkg::DW-1:0]    o_estimate, o_read_value;
    logic                              o_is_heavy;
    int                                fail_count, pending;
    int                                quiet_cycles;
    int                                send_idle_pct, recv_stall_pct;
    logic [cshh_pkg::DW-1:0]           hot_keys [8];

    count_sketch_heavy_hitter_top dut (.*);

    tb_count_sketch_heavy_hitter_checker checker_u (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_idx, .i_cfg_data,
        .i_in_valid, .i_in_stall(o_in_stall), .i_command, .i_key, .i_amount,
        .i_counter_index, .i_counter_value, .i_out_valid(o_out_valid),
        .i_out_stall, .i_estimate(o_estimate), .i_is_heavy(o_is_heavy),
        .i_read_value(o_read_value), .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk)
        i_out_stall <= ($urandom_range(99) < recv_stall_pct);

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // valid stays high after acceptance until the next word or stop_sending
    task automatic send_word(logic [cshh_pkg::CMD_W-1:0] cmd, logic [cshh_pkg::DW-1:0] key,
                             logic [cshh_pkg::DW-1:0] amt, logic [cshh_pkg::IDX_W-1:0] idx,
                             logic [cshh_pkg::DW-1:0] val);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_command <= cmd; i_key <= key; i_amount <= amt;
        i_counter_index <= idx; i_counter_value <= val;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    task automatic stop_sending();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic write_reg(logic [cshh_pkg::CFG_IDX_W-1:0] idx,
                             logic [cshh_pkg::DW-1:0] data);
        i_cfg_we <= 1'b1; i_cfg_idx <= idx; i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic drain();
        stop_sending();
        while (pending != 0) @(posedge i_clk);
        repeat (450) @(posedge i_clk);
    endtask

    task automatic random_word();
        logic [cshh_pkg::DW-1:0] key;
        int pick;
        pick = $urandom_range(99);
        key = ($urandom_range(3) == 0) ? $urandom() : hot_keys[$urandom_range(7)];
        if (pick < 40) send_word(cshh_pkg::CMD_ADD, key, $urandom_range(1) ? $urandom() :
                                 $urandom_range(20), '0, $urandom());
        else if (pick < 50)
            send_word(cshh_pkg::CMD_SUB, key, $urandom_range(20), '0, $urandom());
        else if (pick < 75)
            send_word(cshh_pkg::CMD_QRY, key, $urandom(), cshh_pkg::IDX_W'($urandom()),
                      $urandom());
        else if (pick < 83)
            send_word(cshh_pkg::CMD_LOAD, key, $urandom(),
                      $urandom_range(1) ? cshh_pkg::IDX_W'($urandom_range(cshh_pkg::NCNT - 1))
                                        : cshh_pkg::IDX_W'($urandom()),
                      $urandom());
        else if (pick < 97)
            send_word(cshh_pkg::CMD_READ, key, $urandom(),
                      $urandom_range(9) ? cshh_pkg::IDX_W'($urandom_range(cshh_pkg::NCNT - 1))
                                        : cshh_pkg::IDX_W'($urandom()),
                      $urandom());
        else send_word(cshh_pkg::CMD_W'($urandom_range(7, 5)), key, $urandom(),
                       cshh_pkg::IDX_W'($urandom()), $urandom());
    endtask

    initial begin
        logic [cshh_pkg::DW-1:0] limits [4];
        logic [cshh_pkg::DW-1:0] bsets [4];
        i_rst_n = 1'b0; i_cfg_we = 1'b0; i_cfg_idx = '0; i_cfg_data = '0;
        i_in_valid = 1'b0; i_command = '0; i_key = '0; i_amount = '0;
        i_counter_index = '0; i_counter_value = '0;
        send_idle_pct = 0; recv_stall_pct = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        foreach (hot_keys[i]) hot_keys[i] = $urandom();
        hot_keys[0] = '0; hot_keys[1] = '1;

        // directed: field extremes, every command, wrap and out-of-range cases
        send_word(cshh_pkg::CMD_ADD, 32'h0, 32'hffffffff, '0, '0);
        send_word(cshh_pkg::CMD_QRY, 32'h0, '0, '0, '0);
        send_word(cshh_pkg::CMD_SUB, 32'hffffffff, 32'h7fffffff, '0, '0);
        send_word(cshh_pkg::CMD_QRY, 32'hffffffff, '0, '0, '0);
        send_word(cshh_pkg::CMD_LOAD, '0, '0, '0, 32'h80000000);
        send_word(cshh_pkg::CMD_LOAD, '0, '0, cshh_pkg::IDX_W'(cshh_pkg::NCNT - 1),
                  32'h7fffffff);
        send_word(cshh_pkg::CMD_LOAD, '0, '0, 14'h3fff, 32'h12345678);
        send_word(cshh_pkg::CMD_READ, '0, '0, '0, '0);
        send_word(cshh_pkg::CMD_READ, '0, '0, cshh_pkg::IDX_W'(cshh_pkg::NCNT - 1), '0);
        send_word(cshh_pkg::CMD_READ, '0, '0, 14'h3fff, '0);
        send_word(cshh_pkg::CMD_READ, '0, '0, cshh_pkg::IDX_W'(cshh_pkg::NCNT), '0);
        for (int i = 0; i < cshh_pkg::NCNT; i += cshh_pkg::MAX_BUCKETS)
            send_word(cshh_pkg::CMD_LOAD, '0, '0, cshh_pkg::IDX_W'(i), 32'h80000000);
        send_word(cshh_pkg::CMD_QRY, 32'h0, '0, '0, '0);
        send_word(3'd5, 32'd1, 32'd1, '0, 32'd1);
        send_word(3'd7, 32'hffffffff, 32'hffffffff, 14'h3fff, 32'hffffffff);
        send_word(cshh_pkg::CMD_QRY, 32'h5a5a5a5a, '0, '0, '0);
        drain();

        bsets  = '{32'd0, 32'd1, 32'd1023, 32'd512};
        limits = '{32'h80000000, 32'h7fffffff, 32'h0, 32'hffffff00};
        for (int ph = 0; ph < 8; ph++) begin
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 59; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 59; end
                default: begin send_idle_pct = 16; recv_stall_pct = 16; end
            endcase
            drain();
            write_reg(cshh_pkg::CFG_BUCKETS, ph < 4 ? bsets[ph] : $urandom_range(2, 40));
            write_reg(cshh_pkg::CFG_THRESHOLD,
                      ph < 4 ? limits[ph] : $urandom_range(30) - 32'd15);
            for (int n = 0; n < 228; n++) begin
                random_word();
                if (n == 100) begin
                    stop_sending();
                    while (pending != 0) @(posedge i_clk);
                end
            end
        end
        send_idle_pct = 0;
        drain();
        if (fail_count == 0) $display("== PASS ==");
        else $display("== FAIL ==");
        $finish;
    end
endmodule
`default_nettype wire
